/* rtl/bcvf_pkg.sv */
package bcvf_pkg;

    localparam int MAX_DIM     = 16384;
    localparam int DIM_W       = 15;
    localparam int BLK_W       = $clog2(MAX_DIM / 4) + 1;
    localparam int CNT_W       = 12;
    localparam int IDX_W       = 24;
    localparam int PROD_W      = CNT_W + BLK_W;
    localparam int FMT_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FMT_W-1:0] FMT_BC1  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_BC2  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_BC3  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BC4  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_BC5  = 3'd4;
    localparam logic [FMT_W-1:0] FMT_BC67 = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_in_item;

    typedef struct packed {
        logic [63:0]      flipped_low;
        logic [63:0]      flipped_high;
        logic [IDX_W-1:0] dest_index;
        logic             last_block;
    } t_out_item;

    typedef struct packed {
        logic [63:0]      block_low;
        logic [63:0]      block_high;
        logic [FMT_W-1:0] format_kind;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] mirror_row;
        logic [BLK_W-1:0] blocks_x;
        logic             last;
    } t_entry;

    // clamp to 1..MAX_DIM, then round up to whole blocks
    function automatic logic [BLK_W-1:0] blocks_of(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] d;
        logic [DIM_W-1:0] s;
        d = dim;
        if (d == '0) begin
            d = DIM_W'(1);
        end
        if (d > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end
        s = d + DIM_W'(3);
        return s[BLK_W+1:2];
    endfunction

    // reverse the four index bytes of a colour block
    function automatic logic [63:0] flip_colour(input logic [63:0] v);
        return {v[39:32], v[47:40], v[55:48], v[63:56], v[31:0]};
    endfunction

    // reverse the four 16-bit explicit alpha rows
    function automatic logic [63:0] flip_explicit_alpha(input logic [63:0] v);
        return {v[15:0], v[31:16], v[47:32], v[63:48]};
    endfunction

    // keep the two endpoints, reverse the 12-bit index rows
    function automatic logic [63:0] flip_interp_alpha(input logic [63:0] v);
        return {v[27:16], v[39:28], v[51:40], v[63:52], v[15:0]};
    endfunction

endpackage

/* rtl/bcvf_front.sv */
module bcvf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bcvf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcvf_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                             i_push,
    input  bcvf_pkg::t_in_item               i_item,
    input  logic                             i_q_full,
    output logic                             o_q_wr,
    output bcvf_pkg::t_entry                 o_entry
);
    import bcvf_pkg::*;

    logic [FMT_W-1:0] r_format;
    logic [BLK_W-1:0] r_blocks_x;
    logic [BLK_W-1:0] r_blocks_y;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             w_cfg_hit;
    logic             w_accept;
    logic [BLK_W-1:0] w_bx_m1;
    logic [BLK_W-1:0] w_by_m1;
    logic             w_last_col;
    logic             w_last_row;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_hit   = i_cfg_valid && (i_cfg_index == CFG_FORMAT ||
                                         i_cfg_index == CFG_WIDTH ||
                                         i_cfg_index == CFG_HEIGHT);
    assign w_accept    = i_push && !i_q_full;

    assign w_bx_m1    = r_blocks_x - BLK_W'(1);
    assign w_by_m1    = r_blocks_y - BLK_W'(1);
    assign w_last_col = ({1'b0, r_col} == w_bx_m1);
    assign w_last_row = ({1'b0, r_row} == w_by_m1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format   <= FMT_BC1;
            r_blocks_x <= blocks_of(DIM_W'(4));
            r_blocks_y <= blocks_of(DIM_W'(4));
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FORMAT: begin
                        r_format <= i_cfg_data[FMT_W-1:0];
                    end
                    CFG_WIDTH: begin
                        r_blocks_x <= blocks_of(i_cfg_data);
                    end
                    CFG_HEIGHT: begin
                        r_blocks_y <= blocks_of(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_q_wr = w_accept;

    always_comb begin
        o_entry.block_low   = i_item.block_low;
        o_entry.block_high  = i_item.block_high;
        o_entry.format_kind = r_format;
        o_entry.col         = r_col;
        o_entry.mirror_row  = w_by_m1[CNT_W-1:0] - r_row;
        o_entry.blocks_x    = r_blocks_x;
        o_entry.last        = w_last_col && w_last_row;
    end

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_blocks_x)
        else $error("column counter beyond blocks per row");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < r_blocks_y)
        else $error("row counter beyond block rows");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_col == '0 && r_row == '0))
        else $error("register write did not restart the level");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && o_entry.last && !w_cfg_hit) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the final block");
`endif

endmodule

/* rtl/bcvf_queue.sv */
module bcvf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  bcvf_pkg::t_entry  i_wr_data,
    output logic              o_full,
    input  logic              i_rd,
    output bcvf_pkg::t_entry  o_head,
    output logic              o_empty
);
    import bcvf_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   w_wr;
    logic                   w_rd;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QUEUE_PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QUEUE_PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* rtl/bcvf_back.sv */
module bcvf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcvf_pkg::t_entry   i_head,
    input  logic               i_q_empty,
    output logic               o_q_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output bcvf_pkg::t_out_item o_data
);
    import bcvf_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_out_item         r_out;
    logic              w_take;
    logic [63:0]       w_flo;
    logic [63:0]       w_fhi;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_dest;

    // load a new result whenever the queue holds one and the output slot is free or being drained
    assign w_take = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd = w_take;

    always_comb begin
        unique case (i_head.format_kind)
            FMT_BC1: begin
                w_flo = flip_colour(i_head.block_low);
                w_fhi = '0;
            end
            FMT_BC2: begin
                w_flo = flip_explicit_alpha(i_head.block_low);
                w_fhi = flip_colour(i_head.block_high);
            end
            FMT_BC3: begin
                w_flo = flip_interp_alpha(i_head.block_low);
                w_fhi = flip_colour(i_head.block_high);
            end
            FMT_BC4: begin
                w_flo = flip_interp_alpha(i_head.block_low);
                w_fhi = '0;
            end
            FMT_BC5: begin
                w_flo = flip_interp_alpha(i_head.block_low);
                w_fhi = flip_interp_alpha(i_head.block_high);
            end
            default: begin
                w_flo = i_head.block_low;
                w_fhi = i_head.block_high;
            end
        endcase
    end

    assign w_prod = PROD_W'(i_head.mirror_row) * PROD_W'(i_head.blocks_x);
    assign w_dest = w_prod + PROD_W'(i_head.col);

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.flipped_low  <= w_flo;
            r_out.flipped_high <= w_fhi;
            r_out.dest_index   <= w_dest[IDX_W-1:0];
            r_out.last_block   <= i_head.last;
        end
    end

    assign o_empty = !r_valid;
    assign o_data  = r_out;

endmodule

/* rtl/bc_block_vertical_flip.sv */
// Vertical flip of one mip level of a BC1..BC7 texture. Push the level's 4x4 blocks in
// raster order; each comes back with its pixel rows reversed (BC6H, BC7 and unknown
// codes as is) and with its destination block index in the mirrored block row, and the
// final block of the level is flagged, after which the next block starts a new level. It
// sustains one block per clock in both directions while the output is popped; a pushed
// block is queued, then registered in the back stage, a bit permutation plus one 12x13
// multiply and add for the index. A two-entry queue separates the counter front end from
// the back stage. Register writes are always ready; any write to format, width or height
// restarts the level, and should be issued only while no blocks are in flight.
module bc_block_vertical_flip (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bcvf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcvf_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  bcvf_pkg::t_in_item              i_data,
    output logic                            empty,
    input  logic                            pop,
    output bcvf_pkg::t_out_item             o_data
);
    import bcvf_pkg::*;

    t_entry w_wr_entry;
    t_entry w_head;
    logic   w_q_wr;
    logic   w_q_rd;
    logic   w_q_full;
    logic   w_q_empty;

    assign full = w_q_full;

    bcvf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_data),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr),
        .o_entry     (w_wr_entry)
    );

    bcvf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_wr_entry),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_head    (w_head),
        .o_empty   (w_q_empty)
    );

    bcvf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_empty (w_q_empty),
        .o_q_rd    (w_q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_data    (o_data)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bcvf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT    = 1000;
    localparam int TARGET_BLOCKS = 750;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FORMAT;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in_item             i_data      = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_out_item            o_data;

    bc_block_vertical_flip i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data)
    );

    // predictor state: registers and raster position of the next block
    logic [FMT_W-1:0] fmt_now   = FMT_BC1;
    logic [DIM_W-1:0] width_px  = DIM_W'(4);
    logic [DIM_W-1:0] height_px = DIM_W'(4);
    int               col_next  = 0;
    int               row_next  = 0;

    t_in_item  pending_blocks[$];
    t_out_item expected_blocks[$];
    t_out_item oldest_expected;

    int blocks_queued   = 0;
    int blocks_accepted = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;
    int push_gap        = 0;
    int pop_gap         = 0;
    bit push_steady     = 1'b0;
    bit pop_steady      = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] reverse_colour_rows(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            r[32 + 8*k +: 8] = v[56 - 8*k +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] reverse_alpha_rows(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 4; k++) begin
            r[16*k +: 16] = v[48 - 16*k +: 16];
        end
        return r;
    endfunction

    // endpoints stay, the four 12-bit index rows swap ends
    function automatic logic [63:0] reverse_index_rows(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            r[16 + 12*k +: 12] = v[52 - 12*k +: 12];
        end
        return r;
    endfunction

    function automatic int blocks_across(input logic [DIM_W-1:0] dim);
        int d;
        d = (dim == '0) ? 1 : int'(dim);
        if (d > MAX_DIM) begin
            d = MAX_DIM;
        end
        return (d + 3) / 4;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DIM_W-1:0] val);
        case (idx)
            CFG_FORMAT: fmt_now   = val[FMT_W-1:0];
            CFG_WIDTH:  width_px  = val;
            CFG_HEIGHT: height_px = val;
            default:    return;
        endcase
        col_next = 0;
        row_next = 0;
    endfunction

    function automatic void predict_block(input t_in_item blk);
        t_out_item res;
        int        bx;
        int        by;
        int        col;
        int        row;
        bx  = blocks_across(width_px);
        by  = blocks_across(height_px);
        col = (col_next >= bx) ? bx - 1 : col_next;
        row = (row_next >= by) ? by - 1 : row_next;
        case (fmt_now)
            FMT_BC1: begin
                res.flipped_low  = reverse_colour_rows(blk.block_low);
                res.flipped_high = '0;
            end
            FMT_BC2: begin
                res.flipped_low  = reverse_alpha_rows(blk.block_low);
                res.flipped_high = reverse_colour_rows(blk.block_high);
            end
            FMT_BC3: begin
                res.flipped_low  = reverse_index_rows(blk.block_low);
                res.flipped_high = reverse_colour_rows(blk.block_high);
            end
            FMT_BC4: begin
                res.flipped_low  = reverse_index_rows(blk.block_low);
                res.flipped_high = '0;
            end
            FMT_BC5: begin
                res.flipped_low  = reverse_index_rows(blk.block_low);
                res.flipped_high = reverse_index_rows(blk.block_high);
            end
            default: begin
                res.flipped_low  = blk.block_low;
                res.flipped_high = blk.block_high;
            end
        endcase
        res.dest_index = IDX_W'((by - 1 - row) * bx + col);
        res.last_block = (col == bx - 1) && (row == by - 1);
        expected_blocks.insert(expected_blocks.size(), res);
        if (col + 1 < bx) begin
            col_next = col + 1;
            row_next = row;
        end else begin
            col_next = 0;
            row_next = (row + 1 < by) ? row + 1 : 0;
        end
    endfunction

    // mostly back-to-back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return DIM_W'($urandom_range(1, 24));
        if (r < 78) return '0;
        if (r < 86) return DIM_W'(MAX_DIM);
        if (r < 92) return DIM_W'($urandom_range(MAX_DIM + 1, 32767));
        return DIM_W'($urandom_range(25, MAX_DIM));
    endfunction

    // block sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (push && !full) begin
                predict_block(i_data);
                blocks_accepted++;
                if ($urandom_range(0, 49) == 0) begin
                    push_steady = !push_steady;
                end
                push_gap = push_steady ? 0 : pick_gap();
            end
            if (push && full) begin
                // hold the request until it is taken
            end else if (push_gap != 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
                push   <= 1'b1;
                i_data <= pending_blocks.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result: dest_index %0d", o_data.dest_index);
                    mismatches++;
                end else begin
                    oldest_expected = expected_blocks.pop_front();
                    if (o_data.flipped_low !== oldest_expected.flipped_low) begin
                        $error("flipped_low: expected %h, got %h",
                               oldest_expected.flipped_low, o_data.flipped_low);
                        mismatches++;
                    end
                    if (o_data.flipped_high !== oldest_expected.flipped_high) begin
                        $error("flipped_high: expected %h, got %h",
                               oldest_expected.flipped_high, o_data.flipped_high);
                        mismatches++;
                    end
                    if (o_data.dest_index !== oldest_expected.dest_index) begin
                        $error("dest_index: expected %0d, got %0d",
                               oldest_expected.dest_index, o_data.dest_index);
                        mismatches++;
                    end
                    if (o_data.last_block !== oldest_expected.last_block) begin
                        $error("last_block: expected %b, got %b",
                               oldest_expected.last_block, o_data.last_block);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 49) == 0) begin
                    pop_steady = !pop_steady;
                end
                pop_gap = pop_steady ? 0 : pick_gap();
            end
            if (pop_gap != 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic queue_block(input logic [63:0] lo, input logic [63:0] hi);
        pending_blocks.insert(pending_blocks.size(),
                              t_in_item'{block_low: lo, block_high: hi});
        blocks_queued++;
    endtask

    // stop at the block budget
    task automatic queue_random(input int n);
        for (int k = 0; k < n && blocks_queued < TARGET_BLOCKS; k++) begin
            queue_block({$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // returns at a rising edge once every queued block has come back
    task automatic wait_idle();
        @(posedge i_clk);
        while (blocks_accepted != blocks_queued || expected_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // leaves valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic configure(input logic [FMT_W-1:0] fmt, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        int start;
        start = $urandom_range(0, 2);
        wait_idle();
        for (int k = 0; k < 3; k++) begin
            case ((start + k) % 3)
                0:       write_reg(CFG_FORMAT, {(DIM_W - FMT_W)'($urandom), fmt});
                1:       write_reg(CFG_WIDTH, w);
                default: write_reg(CFG_HEIGHT, h);
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [FMT_W-1:0] fmt;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               level;
        int               n;
        int               r;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one-block levels
        queue_block('1, '1);
        queue_block(64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA);

        // every format code, the two unknown ones included
        for (int f = 0; f < 8; f++) begin
            configure(FMT_W'(f), DIM_W'(8), DIM_W'(4));
            if (f % 2 == 0) begin
                queue_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
            end else begin
                queue_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
            end
        end

        // zero width acts as one, oversized height saturates
        configure(FMT_BC5, '0, DIM_W'(32767));
        queue_random(2);
        // largest level: destination index near the top of its range
        configure(FMT_BC3, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
        queue_random(2);

        // a write past the register list must not restart the level
        configure(FMT_BC4, DIM_W'(9), DIM_W'(5));
        queue_random(2);
        wait_idle();
        write_reg(CFG_SPARE, '1);
        i_cfg_valid <= 1'b0;
        queue_random(4);

        while (blocks_queued < TARGET_BLOCKS) begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
                wait_idle();
                write_reg(CFG_SPARE, DIM_W'($urandom));
                i_cfg_valid <= 1'b0;
                queue_random($urandom_range(1, 20));
            end else if (r == 1) begin
                queue_random($urandom_range(1, 20));
            end else begin
                fmt = ($urandom_range(0, 99) < 90) ? FMT_W'($urandom_range(0, 5))
                                                   : FMT_W'($urandom_range(6, 7));
                w = pick_dim();
                h = pick_dim();
                configure(fmt, w, h);
                level = blocks_across(w) * blocks_across(h);
                if (level <= 48) begin
                    n = level * $urandom_range(1, 3) + $urandom_range(0, level - 1);
                end else begin
                    n = $urandom_range(4, 40);
                end
                queue_random(n);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bcvf_pkg.sv
rtl/bcvf_front.sv
rtl/bcvf_queue.sv
rtl/bcvf_back.sv
rtl/bc_block_vertical_flip.sv
tb/tb_top.sv
